FILE: sv/ucb_pkg.sv
// ----------------------------------------------------------------------------
// ucb_pkg: shared types and constants of the USB/CAN packet bridge
// Item codes, result kinds, register indexes and the command word that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ucb_pkg;

  localparam int PKT_LEN     = 65;
  localparam int FRAME_COUNT = 9;
  localparam int FULL_WORDS  = FRAME_COUNT - 1;
  localparam int REQ_WORDS   = FRAME_COUNT;
  localparam int COUNT_W     = 7;
  localparam int TICK_WIDTH  = 16;
  localparam logic [31:0] TICK_MAX = 32'((64'd1 << TICK_WIDTH) - 64'd1);

  localparam logic [COUNT_W-1:0] COUNT_PKT = COUNT_W'(PKT_LEN);
  localparam logic [3:0] LAST_FRAME = 4'(FRAME_COUNT - 1);

  // input item types
  localparam logic [1:0] REQ_USB  = 2'd0;
  localparam logic [1:0] REQ_CAN  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CAN_TX = 2'd0;
  localparam logic [1:0] KIND_USB    = 2'd1;
  localparam logic [1:0] KIND_FWD    = 2'd2;

  // command codes between front and back
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [10:0] SEND_ID_RESET = 11'd1921;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  // accepted request headers
  localparam logic [7:0] HDR_A = 8'h40;
  localparam logic [7:0] HDR_B = 8'h23;
  localparam logic [7:0] HDR_C = 8'hFD;
  localparam logic [7:0] HDR_D = 8'hFE;
  localparam logic [7:0] HDR_E = 8'h41;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  usb_byte;
    logic        usb_end;
    logic [28:0] rx_ident;
    logic        rx_is_extended;
    logic [63:0] rx_payload;
  } cmd_t;

  typedef struct packed {
    logic [10:0] send_id;
    logic [15:0] timeout_ms;
  } cfg_t;

  function automatic logic header_ok(input logic [7:0] h);
    return (h == HDR_A) || (h == HDR_B) || (h == HDR_C) || (h == HDR_D) || (h == HDR_E);
  endfunction

endpackage

`default_nettype wire

FILE: sv/ucb_if.sv
// ----------------------------------------------------------------------------
// ucb_if: stream channels of the USB/CAN packet bridge
// Input item channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  usb_byte;
  logic        usb_end;
  logic [28:0] rx_ident;
  logic        rx_is_extended;
  logic [63:0] rx_payload;

  modport source (output valid, req_type, usb_byte, usb_end, rx_ident, rx_is_extended,
                  rx_payload, input ready);
  modport sink (input valid, req_type, usb_byte, usb_end, rx_ident, rx_is_extended,
                rx_payload, output ready);
endinterface

interface ucb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  res_kind;
  logic [28:0] out_ident;
  logic        out_extended;
  logic [63:0] out_payload;
  logic [3:0]  out_len;
  logic        run_end;

  modport source (output valid, res_kind, out_ident, out_extended, out_payload, out_len,
                  run_end, input ready);
  modport sink (input valid, res_kind, out_ident, out_extended, out_payload, out_len,
                run_end, output ready);
endinterface

`default_nettype wire

FILE: sv/ucb_front.sv
// ----------------------------------------------------------------------------
// ucb_front: input classifier
// Accepts input beats, turns them into commands and drops unused item types.
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_front import ucb_pkg::*; (
  ucb_in_if.sink in_ch,
  output logic   push_valid,
  input  logic   push_ready,
  output cmd_t   cmd
);

  logic known;

  always_comb begin
    known  = 1'b1;
    cmd.op = CMD_BYTE;
    case (in_ch.req_type)
      REQ_USB:  cmd.op = CMD_BYTE;
      REQ_CAN:  cmd.op = CMD_FRAME;
      REQ_TICK: cmd.op = CMD_TICK;
      default:  known = 1'b0;
    endcase
    cmd.usb_byte       = in_ch.usb_byte;
    cmd.usb_end        = in_ch.usb_end;
    cmd.rx_ident       = in_ch.rx_ident;
    cmd.rx_is_extended = in_ch.rx_is_extended;
    cmd.rx_payload     = in_ch.rx_payload;
  end

  // unknown types are taken and dropped here
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && known;

endmodule

`default_nettype wire

FILE: sv/ucb_cmd_queue.sv
// ----------------------------------------------------------------------------
// ucb_cmd_queue: two-entry command queue
// Decouples the classifier from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_cmd_queue import ucb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/ucb_back.sv
// ----------------------------------------------------------------------------
// ucb_back: bridge engine
// Assembles requests, collects reply frames, runs the timeout and plays out
// nine-beat runs and forwarded frames through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_back import ucb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  ucb_out_if.source  out_ch
);

  logic [63:0]           req_mem [0:REQ_WORDS-1];
  logic [63:0]           rsp_mem [0:FULL_WORDS-1];
  logic [7:0]            rsp_last;
  logic [COUNT_W-1:0]    request_count;
  logic [COUNT_W-1:0]    count_inc;
  logic                  awaiting_reply;
  logic [3:0]            reply_frames;
  logic [TICK_WIDTH-1:0] wait_ticks;
  logic                  run_active;
  logic                  run_src;
  logic [3:0]            run_idx;

  logic        o_valid;
  logic [1:0]  o_kind;
  logic [28:0] o_ident;
  logic        o_ext;
  logic [63:0] o_payload;
  logic [3:0]  o_len;
  logic        o_end;

  logic        load;
  logic        pop;
  logic        is_byte;
  logic        is_frame;
  logic        is_tick;
  logic        accept_req;
  logic        frame_done;
  logic        forward;
  logic [31:0] limit;
  logic        timeout_hit;
  logic [63:0] run_word;
  logic [7:0]  run_last;

  assign load      = !o_valid || out_ch.ready;
  assign cmd_ready = !run_active && load;
  assign pop       = cmd_valid && cmd_ready;
  assign is_byte   = pop && (cmd.op == CMD_BYTE);
  assign is_frame  = pop && (cmd.op == CMD_FRAME);
  assign is_tick   = pop && (cmd.op == CMD_TICK);

  // count saturates one past the packet length
  assign count_inc = (request_count <= COUNT_PKT) ? request_count + 1'b1 : request_count;

  assign accept_req = is_byte && cmd.usb_end && (count_inc == COUNT_PKT) &&
                      !awaiting_reply && header_ok(req_mem[0][7:0]);
  assign frame_done = is_frame && awaiting_reply && (reply_frames == LAST_FRAME);
  assign forward    = is_frame && !awaiting_reply;

  assign limit       = ({16'd0, cfg.timeout_ms} > TICK_MAX) ? TICK_MAX
                                                            : {16'd0, cfg.timeout_ms};
  assign timeout_hit = 32'(wait_ticks) >= limit;

  assign run_word = run_src ? rsp_mem[run_idx[2:0]] : req_mem[run_idx];
  assign run_last = run_src ? rsp_last : req_mem[REQ_WORDS-1][7:0];

  // packet stores
  always_ff @(posedge clk) begin
    if (is_byte && (request_count < COUNT_PKT)) begin
      req_mem[request_count[6:3]][{request_count[2:0], 3'b000} +: 8] <= cmd.usb_byte;
    end
    if (is_frame && awaiting_reply) begin
      if (reply_frames < LAST_FRAME) begin
        rsp_mem[reply_frames[2:0]] <= cmd.rx_payload;
      end else begin
        rsp_last <= cmd.rx_payload[7:0];
      end
    end
  end

  // bridge control
  always_ff @(posedge clk) begin
    if (rst) begin
      request_count  <= '0;
      awaiting_reply <= 1'b0;
      reply_frames   <= 4'd0;
      wait_ticks     <= '0;
      run_active     <= 1'b0;
      run_src        <= 1'b0;
      run_idx        <= 4'd0;
    end else begin
      if (is_byte) begin
        request_count <= cmd.usb_end ? '0 : count_inc;
      end
      if (accept_req) begin
        awaiting_reply <= 1'b1;
        reply_frames   <= 4'd0;
        wait_ticks     <= '0;
        run_active     <= 1'b1;
        run_src        <= 1'b0;
        run_idx        <= 4'd0;
      end
      if (is_frame && awaiting_reply) begin
        if (frame_done) begin
          reply_frames   <= 4'd0;
          awaiting_reply <= 1'b0;
          run_active     <= 1'b1;
          run_src        <= 1'b1;
          run_idx        <= 4'd0;
        end else begin
          reply_frames <= reply_frames + 4'd1;
        end
      end
      if (is_tick && awaiting_reply) begin
        if (timeout_hit) begin
          awaiting_reply <= 1'b0;
          reply_frames   <= 4'd0;
          wait_ticks     <= '0;
        end else begin
          wait_ticks <= wait_ticks + 1'b1;
        end
      end
      // advance the run one beat per free output slot
      if (run_active && load) begin
        run_idx <= run_idx + 4'd1;
        if (run_idx == LAST_FRAME) begin
          run_active <= 1'b0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= run_active || forward;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (run_active) begin
        o_kind  <= run_src ? KIND_USB : KIND_CAN_TX;
        o_ident <= run_src ? 29'd0 : {18'd0, cfg.send_id};
        o_ext   <= 1'b0;
        if (run_idx == LAST_FRAME) begin
          o_payload <= {56'd0, run_last};
          o_len     <= 4'd1;
          o_end     <= 1'b1;
        end else begin
          o_payload <= run_word;
          o_len     <= 4'd8;
          o_end     <= 1'b0;
        end
      end else begin
        o_kind    <= KIND_FWD;
        o_ident   <= cmd.rx_ident;
        o_ext     <= cmd.rx_is_extended;
        o_payload <= cmd.rx_payload;
        o_len     <= 4'd8;
        o_end     <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.res_kind     = o_kind;
  assign out_ch.out_ident    = o_ident;
  assign out_ch.out_extended = o_ext;
  assign out_ch.out_payload  = o_payload;
  assign out_ch.out_len      = o_len;
  assign out_ch.run_end      = o_end;

endmodule

`default_nettype wire

FILE: sv/usb_can_packet_bridge_unit.sv
// ----------------------------------------------------------------------------
// usb_can_packet_bridge_unit: USB request to CAN frame bridge
// Top level: configuration registers, classifier, command queue, engine.
// ----------------------------------------------------------------------------
// The engine takes a USB byte, a tick or a frame that is stored as a reply
// whenever no run is active and its output register can load. The engine
// takes no command while a result beat waits in its output register, so the
// two-entry command queue absorbs up to two input beats while the result port
// stalls. A forwarded frame gives one result beat in the cycle after it leaves
// the queue. A bridged request or a completed reply gives a run of nine beats,
// one per cycle while the result port takes them, played out through the
// output register; during a run the engine takes no command and the queue
// takes up to two more items and then holds ready low. Write send_id and
// timeout_ms only while the block is idle.
`default_nettype none

module usb_can_packet_bridge_unit import ucb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ucb_in_if.sink                in_ch,
  ucb_out_if.source             out_ch
);

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic push_valid;
  logic push_ready;
  logic pop_valid;
  logic pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.send_id    <= SEND_ID_RESET;
      cfg.timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEND_ID: cfg.send_id    <= cfg_data[10:0];
        CFG_TIMEOUT: cfg.timeout_ms <= cfg_data[15:0];
        default:     cfg.send_id    <= cfg.send_id;
      endcase
    end
  end

  ucb_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .cmd        (front_cmd)
  );

  ucb_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (back_cmd)
  );

  ucb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (back_cmd),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: sv/ucb_checker.sv
// ----------------------------------------------------------------------------
// ucb_checker: port-level checks of the packet bridge
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ucb_checker import ucb_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  res_kind,
  input logic [28:0] out_ident,
  input logic        out_extended,
  input logic [63:0] out_payload,
  input logic [3:0]  out_len,
  input logic        run_end
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload) && $stable(res_kind))
    else $error("result beat changed while stalled");

  a_fwd: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_kind == KIND_FWD) |-> !run_end && (out_len == 4'd8))
    else $error("forwarded frame marked as run end or short");

  a_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_end |-> (out_len == 4'd1) && (out_payload[63:8] == 56'd0))
    else $error("run tail carries more than one byte");

  a_usb: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_kind == KIND_USB) |-> (out_ident == 29'd0) && !out_extended)
    else $error("response chunk carries an identifier");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind usb_can_packet_bridge_unit ucb_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .res_kind     (out_ch.res_kind),
  .out_ident    (out_ch.out_ident),
  .out_extended (out_ch.out_extended),
  .out_payload  (out_ch.out_payload),
  .out_len      (out_ch.out_len),
  .run_end      (out_ch.run_end)
);

`default_nettype wire
